>>> rtl/fgaq_pkg.sv
// Package: shared types and constants of the feature grid area query block
package fgaq_pkg;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_QUERY  = 2'd2
	} opcode_t;

	localparam logic CFG_COLUMN_SCALE = 1'b0;
	localparam logic [15:0] SCALE_RESET = 16'd1024;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [2:0]  level;
		logic [15:0] radius;
		logic [2:0]  min_level;
		logic signed [3:0] max_level;
	} item_t;

	typedef struct packed {
		logic [10:0] feature_index;
		logic        hit_valid;
		logic        in_grid;
		logic        store_full;
		logic        overflow;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [15:0] index;
		logic [15:0] data;
	} cfg_t;

endpackage

>>> rtl/fgaq_if.sv
// Interfaces: valid/ready item, result and configuration channels
interface fgaq_item_if;
	logic valid;
	logic ready;
	fgaq_pkg::item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fgaq_result_if;
	logic valid;
	logic ready;
	fgaq_pkg::result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fgaq_cfg_if;
	logic valid;
	logic ready;
	fgaq_pkg::cfg_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/feature_grid_area_query.sv
// Top level: feature grid area query with configuration registers
// channel | dir | transfer
// in_ch   | in  | one item: clear, insert or query
// out_ch  | out | result items, last on final one
// cfg_ch  | in  | register index and data
// Insert: one memory read stage, of cell occupancy and tail, precedes the store
// update and the result. Query: walks every covered cell and every keypoint listed
// in it. Clear: a clearing pass over cell occupancy. Reset runs the same clearing pass
// before the first item is taken; a stalled output holds the walk, and the input
// stalls once four items wait in the front queue.
module feature_grid_area_query #(
	parameter int GRID_COLUMNS = 64,
	parameter int GRID_ROWS = 48,
	parameter int MAX_FEATURES = 2048,
	parameter int MAX_HITS = 64
) (
	input logic clk,
	input logic arst_n,
	fgaq_item_if.sink in_ch,
	fgaq_result_if.source out_ch,
	fgaq_cfg_if.sink cfg_ch
);
	logic [15:0] col_q, row_q;
	logic qv, qt;
	fgaq_pkg::item_t qi;

	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= fgaq_pkg::SCALE_RESET; row_q <= fgaq_pkg::SCALE_RESET;
		end else if (cfg_ch.valid && cfg_ch.data.index[15:1] == '0) begin
			if (cfg_ch.data.index[0] == fgaq_pkg::CFG_COLUMN_SCALE) col_q <= cfg_ch.data.data;
			else row_q <= cfg_ch.data.data;
		end
	end

	fgaq_front #(.DEPTH(4)) u_front (.clk, .arst_n, .in_ch,
		.out_valid(qv), .out_take(qt), .out_item(qi));

	fgaq_back #(.GRID_COLUMNS(GRID_COLUMNS), .GRID_ROWS(GRID_ROWS),
		.MAX_FEATURES(MAX_FEATURES), .MAX_HITS(MAX_HITS)) u_back (
		.clk, .arst_n, .in_valid(qv), .in_take(qt), .in_item(qi),
		.column_scale(col_q), .row_scale(row_q), .out_ch);

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.store_full |-> !out_ch.data.hit_valid)
		else $error("store_full with hit");
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.overflow |-> out_ch.data.last)
		else $error("overflow not last");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("result changed while waiting");
endmodule

>>> rtl/fgaq_front.sv
// Front: input queue of accepted items
module fgaq_front #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	fgaq_item_if.sink in_ch,
	output logic out_valid,
	input  logic out_take,
	output fgaq_pkg::item_t out_item
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	fgaq_pkg::item_t mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;
	logic push, pop;

	assign in_ch.ready = (cnt_q != (AW+1)'(DEPTH));
	assign push = in_ch.valid && in_ch.ready;
	assign out_valid = (cnt_q != '0);
	assign pop = out_take && out_valid;
	assign out_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_ch.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

>>> rtl/fgaq_back.sv
// Back: grid store, insert and query sequencer with output register
module fgaq_back #(
	parameter int GRID_COLUMNS = 64,
	parameter int GRID_ROWS = 48,
	parameter int MAX_FEATURES = 2048,
	parameter int MAX_HITS = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_take,
	input  fgaq_pkg::item_t in_item,
	input  logic [15:0] column_scale,
	input  logic [15:0] row_scale,
	fgaq_result_if.source out_ch
);
	localparam int NCELL = GRID_COLUMNS * GRID_ROWS;
	localparam int CW = (NCELL > 1) ? $clog2(NCELL) : 1;
	localparam int FW = $clog2(MAX_FEATURES);
	localparam int HW = $clog2(MAX_HITS + 1);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001, S_CLR   = 9'b000000010, S_INS   = 9'b000000100,
		S_INS2  = 9'b000001000, S_QWIN  = 9'b000010000, S_CELL  = 9'b000100000,
		S_CELL2 = 9'b001000000, S_FEAT  = 9'b010000000, S_EMIT  = 9'b100000000
	} state_t;
	state_t st_q;

	logic [15:0] fx_mem [MAX_FEATURES];
	logic [15:0] fy_mem [MAX_FEATURES];
	logic [2:0]  fl_mem [MAX_FEATURES];
	logic [FW-1:0] nx_mem [MAX_FEATURES];
	logic [FW-1:0] hd_mem [NCELL];
	logic [FW-1:0] tl_mem [NCELL];
	logic occ_mem [NCELL];

	fgaq_pkg::item_t it_q;
	logic [FW:0] cnt_q;
	logic [CW-1:0] clr_q, cell_q;
	logic [31:0] px_s1, py_s1;
	logic [8:0] x1_q, y0_q, y1_q, ix_q, iy_q;
	logic [FW-1:0] idx_q, tail_q;
	logic occ_rd_q;
	logic [FW-1:0] hd_rd_q, tl_rd_q, nx_rd_q;
	logic [15:0] fx_rd_q, fy_rd_q;
	logic [2:0] fl_rd_q;
	logic [HW-1:0] n_q;
	logic pend_q, init_q;
	fgaq_pkg::result_t pend_r_q;
	logic out_v_q;
	fgaq_pkg::result_t out_r_q;
	logic [32:0] lx_s1, hx_s1, ly_s1, hy_s1;
	logic lxn_s1, lyn_s1;

	logic out_free;
	assign out_free = !out_v_q || out_ch.ready;
	assign out_ch.valid = out_v_q;
	assign out_ch.data = out_r_q;
	assign in_take = (st_q == S_IDLE) && in_valid;

	logic [16:0] cx_w, cy_w;
	logic ing_w;
	assign cx_w = 17'(({1'b0, px_s1} + 33'd524288) >> 20);
	assign cy_w = 17'(({1'b0, py_s1} + 33'd524288) >> 20);
	assign ing_w = (cx_w < 17'(GRID_COLUMNS)) && (cy_w < 17'(GRID_ROWS));

	logic [CW-1:0] ins_cell;
	assign ins_cell = CW'(cx_w * 17'(GRID_ROWS) + cy_w);

	logic [16:0] dlx, dly;
	logic dlxn, dlyn;
	assign dlxn = in_item.radius > in_item.pos_x;
	assign dlyn = in_item.radius > in_item.pos_y;
	assign dlx = dlxn ? 17'(in_item.radius - in_item.pos_x) : 17'(in_item.pos_x - in_item.radius);
	assign dly = dlyn ? 17'(in_item.radius - in_item.pos_y) : 17'(in_item.pos_y - in_item.radius);

	logic [32:0] lxc, hxc, lyc, hyc;
	logic [9:0] x0w, x1w, y0w, y1w;
	always_comb begin
		lxc = lxn_s1 ? 33'd0 : (lx_s1 >> 20);
		lyc = lyn_s1 ? 33'd0 : (ly_s1 >> 20);
		hxc = 33'(({1'b0, hx_s1} + 34'hFFFFF) >> 20);
		hyc = 33'(({1'b0, hy_s1} + 34'hFFFFF) >> 20);
		x0w = (lxc > 33'(GRID_COLUMNS - 1)) ? 10'(GRID_COLUMNS) : 10'(lxc);
		y0w = (lyc > 33'(GRID_ROWS - 1)) ? 10'(GRID_ROWS) : 10'(lyc);
		x1w = (hxc > 33'(GRID_COLUMNS - 1)) ? 10'(GRID_COLUMNS - 1) : 10'(hxc);
		y1w = (hyc > 33'(GRID_ROWS - 1)) ? 10'(GRID_ROWS - 1) : 10'(hyc);
	end

	logic lvl_ok, in_box, hit;
	logic [16:0] adx, ady;
	always_comb begin
		adx = (fx_rd_q >= it_q.pos_x) ? 17'(fx_rd_q - it_q.pos_x) : 17'(it_q.pos_x - fx_rd_q);
		ady = (fy_rd_q >= it_q.pos_y) ? 17'(fy_rd_q - it_q.pos_y) : 17'(it_q.pos_y - fy_rd_q);
		lvl_ok = (fl_rd_q >= it_q.min_level) &&
			(it_q.max_level[3] || ({1'b0, fl_rd_q} <= it_q.max_level[3:0]));
		in_box = (adx <= 17'(it_q.radius)) && (ady <= 17'(it_q.radius));
		hit = lvl_ok && in_box;
	end

	logic [CW-1:0] cur_cell;
	assign cur_cell = CW'(ix_q) * CW'(GRID_ROWS) + CW'(iy_q);

	fgaq_pkg::result_t emit_r;
	logic feat_go, feat_push, out_load;
	always_comb begin
		emit_r = pend_r_q;
		emit_r.last = 1'b1;
	end
	assign feat_go = (st_q == S_FEAT) && (cell_q != cur_cell) && (!pend_q || out_free);
	assign feat_push = feat_go && hit && pend_q && (n_q != HW'(MAX_HITS));
	assign out_load = feat_push || ((st_q == S_EMIT) && out_free);

	always_ff @(posedge clk) begin
		if (in_take) begin
			it_q <= in_item;
			px_s1 <= in_item.pos_x * column_scale;
			py_s1 <= in_item.pos_y * row_scale;
			lx_s1 <= 33'(dlx) * 33'(column_scale);
			ly_s1 <= 33'(dly) * 33'(row_scale);
			hx_s1 <= 33'(17'(in_item.pos_x) + 17'(in_item.radius)) * 33'(column_scale);
			hy_s1 <= 33'(17'(in_item.pos_y) + 17'(in_item.radius)) * 33'(row_scale);
			lxn_s1 <= dlxn && (dlx != 0);
			lyn_s1 <= dlyn && (dly != 0);
		end
		if (st_q == S_CLR) occ_mem[clr_q] <= 1'b0;
		if (st_q == S_INS2 && !cnt_q[FW]) begin
			fx_mem[cnt_q[FW-1:0]] <= it_q.pos_x;
			fy_mem[cnt_q[FW-1:0]] <= it_q.pos_y;
			fl_mem[cnt_q[FW-1:0]] <= it_q.level;
		end
		if (st_q == S_INS2 && ing_w && !cnt_q[FW]) begin
			if (occ_rd_q) nx_mem[tl_rd_q] <= cnt_q[FW-1:0];
			else hd_mem[ins_cell] <= cnt_q[FW-1:0];
			tl_mem[ins_cell] <= cnt_q[FW-1:0];
			occ_mem[ins_cell] <= 1'b1;
		end
		occ_rd_q <= occ_mem[(st_q == S_INS) ? ins_cell : cur_cell];
		tl_rd_q <= tl_mem[(st_q == S_INS) ? ins_cell : cur_cell];
		hd_rd_q <= hd_mem[cur_cell];
		fx_rd_q <= fx_mem[idx_q];
		fy_rd_q <= fy_mem[idx_q];
		fl_rd_q <= fl_mem[idx_q];
		nx_rd_q <= nx_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR; cnt_q <= '0; clr_q <= '0; out_v_q <= 1'b0;
			pend_q <= 1'b0; n_q <= '0; init_q <= 1'b1;
			x1_q <= '0; y0_q <= '0; y1_q <= '0; ix_q <= '0; iy_q <= '0;
			idx_q <= '0; tail_q <= '0; cell_q <= '0; pend_r_q <= '0; out_r_q <= '0;
		end else begin
			out_v_q <= out_load || (out_v_q && !out_ch.ready);
			case (st_q)
				S_IDLE: if (in_take) begin
					case (in_item.opcode)
						fgaq_pkg::OP_CLEAR: begin clr_q <= '0; st_q <= S_CLR; end
						fgaq_pkg::OP_INSERT: st_q <= S_INS;
						fgaq_pkg::OP_QUERY: st_q <= S_QWIN;
						default: st_q <= S_EMIT;
					endcase
					pend_q <= 1'b0; n_q <= '0;
					pend_r_q <= '{feature_index: '0, hit_valid: 1'b0, in_grid: 1'b0,
						store_full: 1'b0, overflow: 1'b0, last: 1'b1};
				end
				S_CLR: begin
					if (clr_q == CW'(NCELL - 1)) begin
						cnt_q <= '0; init_q <= 1'b0;
						st_q <= init_q ? S_IDLE : S_EMIT;
					end else clr_q <= clr_q + 1'b1;
				end
				S_INS: st_q <= S_INS2;
				S_INS2: begin
					if (cnt_q[FW] || cnt_q >= (FW+1)'(MAX_FEATURES)) begin
						pend_r_q <= '{feature_index: '0, hit_valid: 1'b0, in_grid: 1'b0,
							store_full: 1'b1, overflow: 1'b0, last: 1'b1};
					end else begin
						pend_r_q <= '{feature_index: 11'(cnt_q[FW-1:0]), hit_valid: 1'b1,
							in_grid: ing_w, store_full: 1'b0, overflow: 1'b0, last: 1'b1};
						cnt_q <= cnt_q + 1'b1;
					end
					st_q <= S_EMIT;
				end
				S_QWIN: begin
					x1_q <= 9'(x1w); y0_q <= 9'(y0w); y1_q <= 9'(y1w);
					ix_q <= 9'(x0w); iy_q <= 9'(y0w);
					if (x0w > x1w || y0w > y1w) st_q <= S_EMIT;
					else st_q <= S_CELL;
				end
				S_CELL: st_q <= S_CELL2;
				S_CELL2: begin
					if (occ_rd_q) begin
						idx_q <= hd_rd_q; tail_q <= tl_rd_q; st_q <= S_FEAT;
					end else if (iy_q != y1_q) begin
						iy_q <= iy_q + 1'b1; st_q <= S_CELL;
					end else if (ix_q != x1_q) begin
						ix_q <= ix_q + 1'b1; iy_q <= y0_q; st_q <= S_CELL;
					end else begin
						st_q <= S_EMIT;
					end
					cell_q <= cur_cell;
				end
				S_FEAT: if (cell_q == cur_cell && (!pend_q || out_free)) begin
					cell_q <= ~cur_cell;
				end else if (feat_go) begin
					if (hit && n_q == HW'(MAX_HITS)) begin
						pend_r_q.overflow <= 1'b1;
						st_q <= S_EMIT;
					end else begin
						if (hit) begin
							if (pend_q) out_r_q <= pend_r_q;
							pend_q <= 1'b1; n_q <= n_q + 1'b1;
							pend_r_q <= '{feature_index: 11'(idx_q), hit_valid: 1'b1,
								in_grid: 1'b0, store_full: 1'b0, overflow: 1'b0, last: 1'b0};
						end
						cell_q <= cur_cell;
						if (idx_q != tail_q) idx_q <= nx_rd_q;
						else if (iy_q != y1_q) begin iy_q <= iy_q + 1'b1; st_q <= S_CELL; end
						else if (ix_q != x1_q) begin
							ix_q <= ix_q + 1'b1; iy_q <= y0_q; st_q <= S_CELL;
						end else begin
							st_q <= S_EMIT;
						end
					end
				end
				S_EMIT: if (out_free) begin
					out_r_q <= emit_r;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> verif/feature_grid_area_query_tb.sv
`timescale 1ns / 100ps
// Testbench: feature grid area query, predicted results checked against the block
module feature_grid_area_query_tb;

	localparam int COLS = 64;
	localparam int ROWS = 48;
	localparam int FEATURES = 2048;
	localparam int HITS = 64;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [15:0] REG_COLUMN_SCALE = 16'd0;
	localparam logic [15:0] REG_ROW_SCALE = 16'd1;
	localparam logic [15:0] REG_UNUSED = 16'd5;
	localparam int SETTLE_CYCLES = 3300;
	localparam int STALL_LIMIT = 50000;

	class grid_scoreboard;
		bit [15:0] col_scale = fgaq_pkg::SCALE_RESET;
		bit [15:0] row_scale = fgaq_pkg::SCALE_RESET;
		int unsigned count;
		bit [15:0] fx[FEATURES];
		bit [15:0] fy[FEATURES];
		bit [2:0] fl[FEATURES];
		bit [10:0] nxt[FEATURES];
		bit [10:0] head[COLS*ROWS];
		bit [10:0] tail[COLS*ROWS];
		bit occ[COLS*ROWS];
		fgaq_pkg::result_t pending[$];
		int errors;

		function void write_reg(logic [15:0] idx, logic [15:0] value);
			if (idx == REG_COLUMN_SCALE) col_scale = value;
			else if (idx == REG_ROW_SCALE) row_scale = value;
		endfunction

		function void span(longint c, longint r, longint s, longint lim,
				output longint lo, output longint hi);
			longint d;
			longint b;
			d = c - r;
			if (d >= 0) lo = (d * s) >>> 20;
			else lo = -(((-d) * s + (1 << 20) - 1) >>> 20);
			if (lo < 0) lo = 0;
			b = ((c + r) * s + (1 << 20) - 1) >>> 20;
			hi = (b > lim - 1) ? lim - 1 : b;
		endfunction

		function void note_item(fgaq_pkg::item_t it);
			fgaq_pkg::result_t res;
			longint x0, x1, y0, y1, cx, cy;
			int n, c, idx, dx, dy;
			bit ovf, lvl_ok, done;
			res = '0;
			res.last = 1'b1;
			if (it.opcode == fgaq_pkg::OP_CLEAR) begin
				count = 0;
				foreach (occ[i]) occ[i] = 1'b0;
				pending = {pending, res};
			end else if (it.opcode == fgaq_pkg::OP_INSERT) begin
				if (count >= FEATURES) begin
					res.store_full = 1'b1;
				end else begin
					fx[count] = it.pos_x;
					fy[count] = it.pos_y;
					fl[count] = it.level;
					cx = (longint'(it.pos_x) * col_scale + (1 << 19)) >>> 20;
					cy = (longint'(it.pos_y) * row_scale + (1 << 19)) >>> 20;
					res.feature_index = 11'(count);
					res.hit_valid = 1'b1;
					if (cx < COLS && cy < ROWS) begin
						c = int'(cx * ROWS + cy);
						if (occ[c]) nxt[tail[c]] = 11'(count);
						else head[c] = 11'(count);
						tail[c] = 11'(count);
						occ[c] = 1'b1;
						res.in_grid = 1'b1;
					end
					count++;
				end
				pending = {pending, res};
			end else if (it.opcode == fgaq_pkg::OP_QUERY) begin
				n = 0;
				ovf = 1'b0;
				span(it.pos_x, it.radius, col_scale, COLS, x0, x1);
				span(it.pos_y, it.radius, row_scale, ROWS, y0, y1);
				for (longint ix = x0; ix <= x1 && !ovf; ix++) begin
					for (longint iy = y0; iy <= y1 && !ovf; iy++) begin
						c = int'(ix * ROWS + iy);
						if (!occ[c]) continue;
						idx = int'(head[c]);
						done = 1'b0;
						for (int st = 0; st < FEATURES && !done; st++) begin
							dx = int'(fx[idx]) - int'(it.pos_x);
							dy = int'(fy[idx]) - int'(it.pos_y);
							if (dx < 0) dx = -dx;
							if (dy < 0) dy = -dy;
							lvl_ok = fl[idx] >= it.min_level &&
								(it.max_level[3] || fl[idx] <= it.max_level[2:0]);
							if (lvl_ok && dx <= it.radius && dy <= it.radius) begin
								if (n >= HITS) begin
									ovf = 1'b1;
									done = 1'b1;
								end else begin
									res = '0;
									res.feature_index = 11'(idx);
									res.hit_valid = 1'b1;
									pending = {pending, res};
									n++;
								end
							end
							if (!done) begin
								if (idx == int'(tail[c])) done = 1'b1;
								else idx = int'(nxt[idx]);
							end
						end
					end
				end
				if (n == 0) begin
					res = '0;
					res.last = 1'b1;
					pending = {pending, res};
				end else begin
					pending[$].overflow = ovf;
					pending[$].last = 1'b1;
				end
			end else begin
				pending = {pending, res};
			end
		endfunction

		function void check_result(fgaq_pkg::result_t got);
			fgaq_pkg::result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				$display("%0t: mismatch expected %p actual %p", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	fgaq_item_if in_ch();
	fgaq_result_if out_ch();
	fgaq_cfg_if cfg_ch();

	grid_scoreboard grid_sb;
	int tx_idle;
	int rx_idle;
	int stall_cycles;
	logic [15:0] recent_x[$];
	logic [15:0] recent_y[$];

	feature_grid_area_query u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= rx_idle);
	end

	always @(posedge clk) begin
		if (cfg_ch.valid && cfg_ch.ready) grid_sb.write_reg(cfg_ch.data.index, cfg_ch.data.data);
		if (in_ch.valid && in_ch.ready) grid_sb.note_item(in_ch.data);
		if (out_ch.valid && out_ch.ready) grid_sb.check_result(out_ch.data);
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic send_item(fgaq_pkg::item_t it);
		int gap;
		if ($urandom_range(99) < tx_idle) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
		if (it.opcode == fgaq_pkg::OP_INSERT) begin
			recent_x = {recent_x, it.pos_x};
			recent_y = {recent_y, it.pos_y};
			if (recent_x.size() > 32) begin
				void'(recent_x.pop_front());
				void'(recent_y.pop_front());
			end
		end
	endtask

	task automatic hold_input();
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	task automatic write_reg(logic [15:0] idx, logic [15:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= '{index: idx, data: value};
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		while (grid_sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic fgaq_pkg::item_t make_item(logic [1:0] op, logic [15:0] x,
			logic [15:0] y, logic [2:0] lvl, logic [15:0] rad, logic [2:0] minl,
			logic [3:0] maxl);
		fgaq_pkg::item_t it;
		it.opcode = op;
		it.pos_x = x;
		it.pos_y = y;
		it.level = lvl;
		it.radius = rad;
		it.min_level = minl;
		it.max_level = maxl;
		return it;
	endfunction

	function automatic fgaq_pkg::item_t random_item();
		fgaq_pkg::item_t it;
		int k;
		int pick;
		it = fgaq_pkg::item_t'($bits(fgaq_pkg::item_t)'({$urandom, $urandom}));
		pick = $urandom_range(99);
		if (pick < 50) begin
			it.opcode = fgaq_pkg::OP_INSERT;
			if ($urandom_range(3) != 0) begin
				it.pos_x = 16'($urandom_range(0, 4095));
				it.pos_y = 16'($urandom_range(0, 3071));
			end
		end else if (pick < 92) begin
			it.opcode = fgaq_pkg::OP_QUERY;
			if (recent_x.size() != 0 && $urandom_range(3) != 0) begin
				k = $urandom_range(0, recent_x.size() - 1);
				it.pos_x = 16'(recent_x[k] + $urandom_range(0, 63) - 32);
				it.pos_y = 16'(recent_y[k] + $urandom_range(0, 63) - 32);
			end
			if ($urandom_range(9) != 0) it.radius = 16'($urandom_range(0, 1500));
			if ($urandom_range(2) != 0) it.min_level = 3'd0;
			if ($urandom_range(2) != 0) it.max_level = -4'sd1;
		end else if (pick < 96) begin
			it.opcode = fgaq_pkg::OP_CLEAR;
		end else begin
			it.opcode = OP_UNUSED;
		end
		return it;
	endfunction

	initial begin
		logic [15:0] col_set[4];
		logic [15:0] row_set[4];
		grid_sb = new();
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		out_ch.ready = 1'b0;
		stall_cycles = 0;
		tx_idle = 10;
		rx_idle = 67;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_item(make_item(fgaq_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0));
		send_item(make_item(fgaq_pkg::OP_INSERT, 16'd0, 16'd0, 3'd0, 0, 0, 0));
		send_item(make_item(fgaq_pkg::OP_INSERT, 16'd100, 16'd120, 3'd7, 0, 0, 0));
		send_item(make_item(fgaq_pkg::OP_INSERT, 16'd110, 16'd90, 3'd3, 0, 0, 0));
		send_item(make_item(fgaq_pkg::OP_INSERT, 16'hFFFF, 16'hFFFF, 3'd5, 0, 0, 0));
		send_item(make_item(fgaq_pkg::OP_INSERT, 16'd2000, 16'hFFFF, 3'd2, 0, 0, 0));
		send_item(make_item(fgaq_pkg::OP_QUERY, 16'd0, 16'd0, 0, 16'd0, 3'd0, -4'sd1));
		send_item(make_item(fgaq_pkg::OP_QUERY, 16'd100, 16'd100, 0, 16'd30, 3'd0, -4'sd8));
		send_item(make_item(fgaq_pkg::OP_QUERY, 16'd100, 16'd100, 0, 16'd30, 3'd7, 4'sd7));
		send_item(make_item(fgaq_pkg::OP_QUERY, 16'd100, 16'd100, 0, 16'd30, 3'd0, 4'sd3));
		send_item(make_item(fgaq_pkg::OP_QUERY, 16'h8000, 16'h8000, 7, 16'hFFFF, 3'd0,
			-4'sd1));
		send_item(make_item(fgaq_pkg::OP_QUERY, 16'hFFFF, 16'hFFFF, 7, 16'd10, 3'd0, -4'sd1));
		send_item(make_item(fgaq_pkg::OP_QUERY, 16'd3000, 16'd3000, 0, 16'd5, 3'd0, -4'sd1));
		send_item(make_item(OP_UNUSED, 16'hFFFF, 16'hFFFF, 7, 16'hFFFF, 7, -4'sd1));
		send_item(make_item(fgaq_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF, 7, 16'hFFFF, 7, 4'sd7));
		send_item(make_item(fgaq_pkg::OP_QUERY, 16'd0, 16'd0, 0, 16'hFFFF, 3'd0, -4'sd1));
		hold_input();
		drain();

		col_set = '{16'd1024, 16'd0, 16'hFFFF, 16'd0};
		row_set = '{16'd1024, 16'hFFFF, 16'd0, 16'd0};
		col_set[3] = 16'($urandom_range(0, 4095));
		row_set[3] = 16'($urandom_range(0, 4095));
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_COLUMN_SCALE, col_set[ph]);
			write_reg(REG_ROW_SCALE, row_set[ph]);
			if (ph == 3) write_reg(REG_UNUSED, 16'hFFFF);
			for (int i = 0; i < 40; i++) begin
				if (ph * 40 + i < 53) begin
					tx_idle = 10;
					rx_idle = 67;
				end else if (ph * 40 + i < 106) begin
					tx_idle = 67;
					rx_idle = 10;
				end else begin
					tx_idle = 0;
					rx_idle = 0;
				end
				send_item(random_item());
			end
			hold_input();
			drain();
		end

		write_reg(REG_COLUMN_SCALE, 16'd1024);
		write_reg(REG_ROW_SCALE, 16'd1024);
		send_item(make_item(fgaq_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0));
		for (int i = 0; i < 70; i++) begin
			send_item(make_item(fgaq_pkg::OP_INSERT, 16'($urandom_range(4000, 4200)),
				16'($urandom_range(4000, 4200)), 3'($urandom_range(0, 7)), 0, 0, 0));
		end
		send_item(make_item(fgaq_pkg::OP_QUERY, 16'd4096, 16'd4096, 0, 16'd2048, 3'd0,
			-4'sd1));
		send_item(make_item(fgaq_pkg::OP_QUERY, 16'd4096, 16'd4096, 0, 16'hFFFF, 3'd7,
			4'sd0));
		send_item(make_item(fgaq_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0));
		hold_input();
		drain();

		if (grid_sb.errors == 0 && grid_sb.pending.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

>>> sim.f
rtl/fgaq_pkg.sv
rtl/fgaq_if.sv
rtl/fgaq_front.sv
rtl/fgaq_back.sv
rtl/feature_grid_area_query.sv
verif/feature_grid_area_query_tb.sv
